@@ rtl/core/lattice_chain_reconnect_move_assert.svh @@
`ifndef LATTICE_CHAIN_RECONNECT_MOVE_ASSERT_SVH
`define LATTICE_CHAIN_RECONNECT_MOVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define LCRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcrm check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define LCRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcrm check failed");

`endif

@@ rtl/core/lcrm_pkg.sv @@
`timescale 1ns / 1ps

package lcrm_pkg;

	// Table sizes
	localparam int MAX_SITES     = 4096;
	localparam int MAX_ENDPOINTS = 256;
	localparam int MAX_DIMENSION = 4;
	localparam int DIM_MIN       = 2;
	localparam int SIDE_MIN      = 2;
	localparam int SIDE_MAX      = 16;

	// Field widths
	localparam int SITE_W    = $clog2(MAX_SITES);
	localparam int BOND_W    = SITE_W + 1;
	localparam int SLOT_W    = $clog2(MAX_ENDPOINTS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int DIM_W     = 3;
	localparam int SIDE_W    = 5;
	localparam int DIR_W     = 3;
	localparam int AXIS_W    = DIR_W - 1;
	localparam int CRD_W     = $clog2(SIDE_MAX);
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = CNT_W;
	localparam int POW_W     = 17;
	localparam int RECIP_W   = 16;

	typedef logic [SITE_W-1:0]    site_t;
	typedef logic [BOND_W-1:0]    bond_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [REQ_W-1:0]     req_t;
	typedef logic [STAT_W-1:0]    status_t;
	typedef logic [DIR_W-1:0]     dir_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

	// One bond table entry: two links
	typedef struct packed {
		bond_t one;
		bond_t two;
	} bond_entry_t;

	localparam bond_t NO_BOND = BOND_W'(MAX_SITES);

	// Request types
	localparam req_t REQ_WRITE_BONDS = 2'd0;
	localparam req_t REQ_WRITE_SLOT  = 2'd1;
	localparam req_t REQ_MOVE        = 2'd2;
	localparam req_t REQ_READ_BONDS  = 2'd3;

	// Result status codes
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_BONDED   = 3'd1;
	localparam status_t ST_C_END    = 3'd2;
	localparam status_t ST_ISOLATED = 3'd3;
	localparam status_t ST_BAD      = 3'd4;

	// Configuration register indexes
	localparam cfg_idx_t CFG_DIM   = 2'd0;
	localparam cfg_idx_t CFG_SIDE  = 2'd1;
	localparam cfg_idx_t CFG_COUNT = 2'd2;

	// Configuration reset values
	localparam logic [DIM_W-1:0]  DIM_RESET   = 3'd3;
	localparam logic [SIDE_W-1:0] SIDE_RESET  = 5'd16;
	localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd2;

	// Link value at or past MAX_SITES means no bond
	function automatic bond_t clean_bond(input bond_t v);
		return (v >= BOND_W'(MAX_SITES)) ? NO_BOND : v;
	endfunction

	// floor(2^16 / side) for side 2..16; quotient low by at most one
	function automatic logic [RECIP_W-1:0] side_recip(input logic [SIDE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		unique case (s)
			5'd2:    r = 16'd32768;
			5'd3:    r = 16'd21845;
			5'd4:    r = 16'd16384;
			5'd5:    r = 16'd13107;
			5'd6:    r = 16'd10922;
			5'd7:    r = 16'd9362;
			5'd8:    r = 16'd8192;
			5'd9:    r = 16'd7281;
			5'd10:   r = 16'd6553;
			5'd11:   r = 16'd5957;
			5'd12:   r = 16'd5461;
			5'd13:   r = 16'd5041;
			5'd14:   r = 16'd4681;
			5'd15:   r = 16'd4369;
			5'd16:   r = 16'd4096;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/lcrm_ram.sv @@
`timescale 1ns / 1ps

module lcrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/lattice_chain_reconnect_move.sv @@
// A bond or slot write gives its result in the cycle after it is taken; a bond read passes
// through S_RD and the result register. An accepted move walks S_POW to S_WC; a rejected one
// returns to idle early. Move cost is set by the bond memory walk (A, B, C reads, three
// write-backs) and the shared reciprocal divider, S_DIV1 then S_DIV2 per coordinate digit.
// Throughput: one transaction at a time; writes may follow every cycle.
// Reset clears the sequencer and the result strobe, presets the config; tables are not cleared.
`timescale 1ns / 1ps

module lattice_chain_reconnect_move (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  lcrm_pkg::cfg_idx_t cfg_index,
	input  lcrm_pkg::cfg_dat_t cfg_data,
	input  logic              start,
	output logic              busy,
	input  lcrm_pkg::req_t    req_type,
	input  lcrm_pkg::site_t   site,
	input  lcrm_pkg::bond_t   bond_one,
	input  lcrm_pkg::bond_t   bond_two,
	input  lcrm_pkg::slot_t   slot,
	input  lcrm_pkg::dir_t    direction,
	input  logic              coin,
	output logic              done,
	output lcrm_pkg::status_t status,
	output lcrm_pkg::bond_t   read_one,
	output lcrm_pkg::bond_t   read_two,
	output lcrm_pkg::site_t   moved_a,
	output lcrm_pkg::site_t   moved_b,
	output lcrm_pkg::bond_t   moved_c
);

	import lcrm_pkg::*;

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_POW  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_DIV1 = 4'd4;
	localparam logic [3:0] S_DIV2 = 4'd5;
	localparam logic [3:0] S_NB   = 4'd6;
	localparam logic [3:0] S_RB   = 4'd7;
	localparam logic [3:0] S_RBW  = 4'd8;
	localparam logic [3:0] S_RC   = 4'd9;
	localparam logic [3:0] S_RCW  = 4'd10;
	localparam logic [3:0] S_WA   = 4'd11;
	localparam logic [3:0] S_WB   = 4'd12;
	localparam logic [3:0] S_WC   = 4'd13;

	localparam int PROD_W = SITE_W + RECIP_W;

	typedef struct packed {
		logic    valid;
		status_t status;
		bond_t   rd_one;
		bond_t   rd_two;
		site_t   a;
		site_t   b;
		bond_t   c;
	} result_t;

	logic [3:0] state_q;

	// Configuration
	logic [DIM_W-1:0]  dim_q;
	logic [SIDE_W-1:0] side_q;
	logic [CNT_W-1:0]  count_q;
	logic [DIM_W-1:0]  dim_eff;
	logic [SIDE_W-1:0] side_eff;
	logic [CNT_W-1:0]  count_eff;

	// Move datapath
	slot_t              slot_q;
	dir_t               dir_q;
	logic               coin_q;
	logic [DIM_W-1:0]   k_q;
	logic [POW_W-1:0]   pw_q;
	logic [POW_W-1:0]   nsites_q;
	logic [SITE_W:0]    stride_q;
	logic [SITE_W:0]    span_q;
	site_t              a_q;
	site_t              v_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AXIS_W-1:0]  cnt_q;
	logic [CRD_W-1:0]   coord_q;
	site_t              b_q;
	bond_t              c_q;
	bond_entry_t        abond_q;
	bond_entry_t        bbond_q;
	bond_entry_t        newa_q;
	bond_entry_t        newb_q;
	bond_entry_t        newc_q;

	// Result registers
	logic    done_q;
	status_t status_q;
	bond_t   read_one_q;
	bond_t   read_two_q;
	site_t   moved_a_q;
	site_t   moved_b_q;
	bond_t   moved_c_q;

	// Memory ports
	logic        bond_we;
	site_t       bond_waddr;
	bond_entry_t bond_wdata;
	site_t       bond_raddr;
	bond_entry_t bond_rdata;
	logic        ep_we;
	slot_t       ep_waddr;
	site_t       ep_wdata;
	slot_t       ep_raddr;
	site_t       ep_rdata;

	logic              accept;
	logic [AXIS_W-1:0] axis;
	logic              bad_cfg;
	logic              bad_a;
	logic              bonded;
	logic              isolated;
	bond_t             c_pick;
	logic              c_end;
	logic [SITE_W-1:0] q0;
	logic [POW_W-1:0]  q0_side;
	site_t             r0;
	site_t             q_fix;
	site_t             r_fix;
	site_t             b_next;
	bond_entry_t       na;
	bond_entry_t       nb;
	bond_entry_t       cbase;
	bond_entry_t       nc;
	result_t           fin;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign axis   = dir_q[DIR_W-1:1];

	// Saturated configuration
	always_comb begin
		if (dim_q < DIM_W'(DIM_MIN))            dim_eff = DIM_W'(DIM_MIN);
		else if (dim_q > DIM_W'(MAX_DIMENSION)) dim_eff = DIM_W'(MAX_DIMENSION);
		else                                    dim_eff = dim_q;
		if (side_q < SIDE_W'(SIDE_MIN))         side_eff = SIDE_W'(SIDE_MIN);
		else if (side_q > SIDE_W'(SIDE_MAX))    side_eff = SIDE_W'(SIDE_MAX);
		else                                    side_eff = side_q;
		count_eff = (count_q > CNT_W'(MAX_ENDPOINTS)) ? CNT_W'(MAX_ENDPOINTS) : count_q;
	end

	// Move checks on slot, lattice size, A and direction
	assign bad_cfg = (CNT_W'(slot_q) >= count_eff) || (nsites_q > POW_W'(MAX_SITES));
	assign bad_a   = (POW_W'(ep_rdata) >= nsites_q) ||
	                 ({1'b0, dir_q} >= {dim_eff, 1'b0});

	// Divider second half: quotient correction and remainder
	always_comb begin
		q0      = prod_q[RECIP_W +: SITE_W];
		q0_side = POW_W'(q0) * POW_W'(side_eff);
		r0      = v_q - q0_side[SITE_W-1:0];
		if (r0 >= SITE_W'(side_eff)) begin
			q_fix = q0 + SITE_W'(1);
			r_fix = r0 - SITE_W'(side_eff);
		end else begin
			q_fix = q0;
			r_fix = r0;
		end
	end

	// Periodic neighbor B of A
	always_comb begin
		if (!dir_q[0]) begin
			if (coord_q == '0) b_next = SITE_W'({1'b0, a_q} + span_q - stride_q);
			else               b_next = SITE_W'({1'b0, a_q} - stride_q);
		end else begin
			if ({1'b0, coord_q} == side_eff - SIDE_W'(1))
				b_next = SITE_W'({1'b0, a_q} - span_q + stride_q);
			else
				b_next = SITE_W'({1'b0, a_q} + stride_q);
		end
	end

	// Checks on the A and B entries, pick of C
	always_comb begin
		bonded   = ({1'b0, b_q} == abond_q.one) || ({1'b0, b_q} == abond_q.two);
		isolated = (bond_rdata.one == NO_BOND) && (bond_rdata.two == NO_BOND);
		if (bond_rdata.one == NO_BOND)      c_pick = bond_rdata.two;
		else if (bond_rdata.two == NO_BOND) c_pick = bond_rdata.one;
		else                                c_pick = coin_q ? bond_rdata.two : bond_rdata.one;
		c_end = (bond_rdata.one == NO_BOND) || (bond_rdata.two == NO_BOND);
	end

	// Rewired entries; C forwards from A or B when it aliases them
	always_comb begin
		na = abond_q;
		if (abond_q.one == NO_BOND) na.one = {1'b0, b_q};
		else                        na.two = {1'b0, b_q};
		nb = bbond_q;
		if (bbond_q.one == c_q) nb.one = {1'b0, a_q};
		else                    nb.two = {1'b0, a_q};
		if (c_q == {1'b0, a_q})      cbase = na;
		else if (c_q == {1'b0, b_q}) cbase = nb;
		else                         cbase = bond_rdata;
		nc = cbase;
		if (cbase.one == {1'b0, b_q}) nc.one = NO_BOND;
		else                          nc.two = NO_BOND;
	end

	// Result of the current cycle, if any
	always_comb begin
		fin.valid  = 1'b0;
		fin.status = ST_OK;
		fin.rd_one = NO_BOND;
		fin.rd_two = NO_BOND;
		fin.a      = '0;
		fin.b      = '0;
		fin.c      = NO_BOND;
		unique case (state_q)
			S_IDLE: begin
				fin.valid = accept &&
				            (req_type == REQ_WRITE_BONDS || req_type == REQ_WRITE_SLOT);
			end
			S_RD: begin
				fin.valid  = 1'b1;
				fin.rd_one = bond_rdata.one;
				fin.rd_two = bond_rdata.two;
			end
			S_CHK: begin
				if (bad_cfg) begin
					fin.valid  = 1'b1;
					fin.status = ST_BAD;
				end else if (bad_a) begin
					fin.valid  = 1'b1;
					fin.status = ST_BAD;
					fin.a      = ep_rdata;
				end
			end
			S_RBW: begin
				fin.a = a_q;
				fin.b = b_q;
				if (bonded) begin
					fin.valid  = 1'b1;
					fin.status = ST_BONDED;
				end else if (isolated) begin
					fin.valid  = 1'b1;
					fin.status = ST_ISOLATED;
				end
			end
			S_RCW: begin
				fin.a = a_q;
				fin.b = b_q;
				fin.c = c_q;
				if (c_end) begin
					fin.valid  = 1'b1;
					fin.status = ST_C_END;
				end
			end
			S_WC: begin
				fin.valid = 1'b1;
				fin.a     = a_q;
				fin.b     = b_q;
				fin.c     = c_q;
			end
			default: begin
				fin.valid = 1'b0;
			end
		endcase
	end

	// Bond memory port selection
	always_comb begin
		unique case (state_q)
			S_NB:    bond_raddr = a_q;
			S_RB:    bond_raddr = b_q;
			S_RC:    bond_raddr = c_q[SITE_W-1:0];
			default: bond_raddr = site;
		endcase
		bond_we         = 1'b0;
		bond_waddr      = site;
		bond_wdata.one  = clean_bond(bond_one);
		bond_wdata.two  = clean_bond(bond_two);
		unique case (state_q)
			S_IDLE: bond_we = accept && (req_type == REQ_WRITE_BONDS);
			S_WA: begin
				bond_we    = 1'b1;
				bond_waddr = a_q;
				bond_wdata = newa_q;
			end
			S_WB: begin
				bond_we    = 1'b1;
				bond_waddr = b_q;
				bond_wdata = newb_q;
			end
			S_WC: begin
				bond_we    = 1'b1;
				bond_waddr = c_q[SITE_W-1:0];
				bond_wdata = newc_q;
			end
			default: bond_we = 1'b0;
		endcase
	end

	// Endpoint memory port selection
	always_comb begin
		ep_raddr = busy ? slot_q : slot;
		if (state_q == S_WC) begin
			ep_we    = 1'b1;
			ep_waddr = slot_q;
			ep_wdata = c_q[SITE_W-1:0];
		end else begin
			ep_we    = accept && (req_type == REQ_WRITE_SLOT);
			ep_waddr = slot;
			ep_wdata = site;
		end
	end

	lcrm_ram #(
		.WIDTH ($bits(bond_entry_t)),
		.DEPTH (MAX_SITES)
	) u_bond_ram (
		.clk   (clk),
		.we    (bond_we),
		.waddr (bond_waddr),
		.wdata (bond_wdata),
		.raddr (bond_raddr),
		.rdata (bond_rdata)
	);

	lcrm_ram #(
		.WIDTH (SITE_W),
		.DEPTH (MAX_ENDPOINTS)
	) u_ep_ram (
		.clk   (clk),
		.we    (ep_we),
		.waddr (ep_waddr),
		.wdata (ep_wdata),
		.raddr (ep_raddr),
		.rdata (ep_rdata)
	);

	// Sequencer, config registers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			dim_q   <= DIM_RESET;
			side_q  <= SIDE_RESET;
			count_q <= COUNT_RESET;
		end else begin
			done_q <= fin.valid;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIM:   dim_q   <= cfg_data[DIM_W-1:0];
					CFG_SIDE:  side_q  <= cfg_data[SIDE_W-1:0];
					CFG_COUNT: count_q <= cfg_data;
					default:   count_q <= count_q;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_READ_BONDS) state_q <= S_RD;
						else if (req_type == REQ_MOVE)   state_q <= S_POW;
					end
				end
				S_RD:   state_q <= S_IDLE;
				S_POW:  if (k_q == dim_eff) state_q <= S_CHK;
				S_CHK:  state_q <= (bad_cfg || bad_a) ? S_IDLE : S_DIV1;
				S_DIV1: state_q <= S_DIV2;
				S_DIV2: state_q <= (cnt_q == axis) ? S_NB : S_DIV1;
				S_NB:   state_q <= S_RB;
				S_RB:   state_q <= S_RBW;
				S_RBW:  state_q <= (bonded || isolated) ? S_IDLE : S_RC;
				S_RC:   state_q <= S_RCW;
				S_RCW:  state_q <= c_end ? S_IDLE : S_WA;
				S_WA:   state_q <= S_WB;
				S_WB:   state_q <= S_WC;
				S_WC:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Move datapath and result payload
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			status_q   <= fin.status;
			read_one_q <= fin.rd_one;
			read_two_q <= fin.rd_two;
			moved_a_q  <= fin.a;
			moved_b_q  <= fin.b;
			moved_c_q  <= fin.c;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					slot_q <= slot;
					dir_q  <= direction;
					coin_q <= coin;
					k_q    <= '0;
					pw_q   <= POW_W'(1);
				end
			end
			// side^k per cycle: stride at the axis, span one past it, site count at dim
			S_POW: begin
				if (k_q == DIM_W'(axis))
					stride_q <= pw_q[SITE_W:0];
				if (k_q == DIM_W'(axis) + DIM_W'(1))
					span_q <= pw_q[SITE_W:0];
				if (k_q == dim_eff) begin
					nsites_q <= pw_q;
				end else begin
					pw_q <= POW_W'(pw_q * POW_W'(side_eff));
					k_q  <= k_q + DIM_W'(1);
				end
			end
			S_CHK: begin
				a_q   <= ep_rdata;
				v_q   <= ep_rdata;
				cnt_q <= '0;
			end
			S_DIV1: prod_q <= PROD_W'(v_q) * PROD_W'(side_recip(side_eff));
			S_DIV2: begin
				v_q     <= q_fix;
				coord_q <= r_fix[CRD_W-1:0];
				cnt_q   <= cnt_q + AXIS_W'(1);
			end
			S_NB:  b_q <= b_next;
			S_RB:  abond_q <= bond_rdata;
			S_RBW: begin
				bbond_q <= bond_rdata;
				c_q     <= c_pick;
			end
			S_RCW: begin
				newa_q <= na;
				newb_q <= nb;
				newc_q <= nc;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign done     = done_q;
	assign status   = status_q;
	assign read_one = read_one_q;
	assign read_two = read_two_q;
	assign moved_a  = moved_a_q;
	assign moved_b  = moved_b_q;
	assign moved_c  = moved_c_q;

endmodule

@@ rtl/core/lcrm_checker.sv @@
`timescale 1ns / 1ps
`include "lattice_chain_reconnect_move_assert.svh"

module lcrm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input lcrm_pkg::cfg_idx_t cfg_index,
	input lcrm_pkg::cfg_dat_t cfg_data,
	input logic              start,
	input logic              busy,
	input lcrm_pkg::req_t    req_type,
	input lcrm_pkg::site_t   site,
	input lcrm_pkg::bond_t   bond_one,
	input lcrm_pkg::bond_t   bond_two,
	input lcrm_pkg::slot_t   slot,
	input lcrm_pkg::dir_t    direction,
	input logic              coin,
	input logic              done,
	input lcrm_pkg::status_t status,
	input lcrm_pkg::bond_t   read_one,
	input lcrm_pkg::bond_t   read_two,
	input lcrm_pkg::site_t   moved_a,
	input lcrm_pkg::site_t   moved_b,
	input lcrm_pkg::bond_t   moved_c
);

	import lcrm_pkg::*;

	// A result always leaves the block idle
	`LCRM_ASSERT_NOW(a_done_idle, done, !busy)

	// A table write reports status OK in the next cycle
	`LCRM_ASSERT_NEXT(a_write_done, start && !busy && (req_type == REQ_WRITE_BONDS || req_type == REQ_WRITE_SLOT), done && status == ST_OK)

	// A bond read returns status OK once its registered RAM read reaches the result register
	`LCRM_ASSERT_NEXT(a_read_done, start && !busy && req_type == REQ_READ_BONDS, ##1 (done && status == ST_OK))

	// A move keeps the block busy with no result in the cycle after it is taken
	`LCRM_ASSERT_NEXT(a_move_busy, start && !busy && req_type == REQ_MOVE, busy && !done)

	// A rejected transaction reports no neighbor, no cut site and no read data
	`LCRM_ASSERT_NOW(a_bad_fields, done && status == ST_BAD, moved_b == '0 && moved_c == NO_BOND && read_one == NO_BOND)

endmodule

bind lattice_chain_reconnect_move lcrm_checker u_lcrm_checker (.*);

@@ dv/lattice_chain_reconnect_move_tb.sv @@
`timescale 1ns / 1ps

module lattice_chain_reconnect_move_tb;
	import lcrm_pkg::*;

	localparam int          CYCLE_LIMIT = 1500000;
	localparam int          SETTLE      = 24;
	localparam cfg_idx_t    CFG_SPARE   = 2'd3;

	// One result transaction as seen on the output ports
	typedef struct {
		status_t status;
		bond_t   read_one;
		bond_t   read_two;
		site_t   moved_a;
		site_t   moved_b;
		bond_t   moved_c;
	} reconnect_result_t;

	// Shadow of both tables and the registers, plus the queue of results still owed
	class move_scoreboard;
		bond_t               link_one [MAX_SITES];
		bond_t               link_two [MAX_SITES];
		site_t               ends     [MAX_ENDPOINTS];
		bit                  slot_set [MAX_ENDPOINTS];
		logic [DIM_W-1:0]    dim_reg;
		logic [SIDE_W-1:0]   side_reg;
		logic [CNT_W-1:0]    cnt_reg;
		reconnect_result_t   owed [$];
		int                  errors;
		int                  kind_tally [4];
		int                  move_tally [5];

		function new();
			dim_reg  = DIM_RESET;
			side_reg = SIDE_RESET;
			cnt_reg  = COUNT_RESET;
			errors   = 0;
		endfunction

		function void configure(cfg_idx_t idx, cfg_dat_t v);
			case (idx)
				CFG_DIM:   dim_reg  = v[DIM_W-1:0];
				CFG_SIDE:  side_reg = v[SIDE_W-1:0];
				CFG_COUNT: cnt_reg  = v;
				default: ;
			endcase
		endfunction

		// register values clamped the way the block uses them
		function int unsigned axes();
			if (dim_reg < DIM_MIN) return DIM_MIN;
			if (dim_reg > MAX_DIMENSION) return MAX_DIMENSION;
			return dim_reg;
		endfunction

		function int unsigned span();
			if (side_reg < SIDE_MIN) return SIDE_MIN;
			if (side_reg > SIDE_MAX) return SIDE_MAX;
			return side_reg;
		endfunction

		function int unsigned slot_limit();
			return (cnt_reg > MAX_ENDPOINTS) ? MAX_ENDPOINTS : cnt_reg;
		endfunction

		function int unsigned lattice_sites();
			int unsigned n;
			n = 1;
			for (int k = 0; k < axes(); k++) n *= span();
			return n;
		endfunction

		// a move only reads the slot when it passes the slot and size checks
		function bit may_move(int unsigned sl);
			return sl >= slot_limit() || lattice_sites() > MAX_SITES || slot_set[sl];
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction

		function reconnect_result_t predict(req_t kind, site_t s, bond_t b1, bond_t b2,
				slot_t sl, dir_t dr, logic cn);
			reconnect_result_t r;
			int unsigned dim, side, n, stride, crd, a, b, c, c0, c1;
			r.status   = ST_OK;
			r.read_one = NO_BOND;
			r.read_two = NO_BOND;
			r.moved_a  = '0;
			r.moved_b  = '0;
			r.moved_c  = NO_BOND;
			case (kind)
				REQ_WRITE_BONDS: begin
					link_one[s] = (b1 >= NO_BOND) ? NO_BOND : b1;
					link_two[s] = (b2 >= NO_BOND) ? NO_BOND : b2;
					return r;
				end
				REQ_READ_BONDS: begin
					r.read_one = link_one[s];
					r.read_two = link_two[s];
					return r;
				end
				REQ_WRITE_SLOT: begin
					ends[sl]     = s;
					slot_set[sl] = 1'b1;
					return r;
				end
				default: ;
			endcase

			// move: validate slot, lattice size, A and direction
			dim  = axes();
			side = span();
			n    = lattice_sites();
			if (sl >= slot_limit() || n > MAX_SITES) begin
				r.status = ST_BAD;
				return r;
			end
			a         = ends[sl];
			r.moved_a = site_t'(a);
			if (a >= n || dr >= 2 * dim) begin
				r.status = ST_BAD;
				return r;
			end

			// periodic neighbor B along the chosen axis
			stride = 1;
			for (int k = 0; k < dr[DIR_W-1:1]; k++) stride *= side;
			crd = (a / stride) % side;
			if (!dr[0])
				b = (crd == 0) ? a + (side - 1) * stride : a - stride;
			else
				b = (crd == side - 1) ? a - (side - 1) * stride : a + stride;
			r.moved_b = site_t'(b);
			if (b == link_one[a] || b == link_two[a]) begin
				r.status = ST_BONDED;
				return r;
			end

			// pick C among the links of B
			c0 = link_one[b];
			c1 = link_two[b];
			if (c0 == NO_BOND && c1 == NO_BOND) begin
				r.status = ST_ISOLATED;
				return r;
			end
			if (c0 == NO_BOND) c = c1;
			else if (c1 == NO_BOND) c = c0;
			else c = cn ? c1 : c0;
			r.moved_c = bond_t'(c);
			if (link_one[c] == NO_BOND || link_two[c] == NO_BOND) begin
				r.status = ST_C_END;
				return r;
			end

			// rewire: A-B joined, B-C cut, C becomes the end
			ends[sl] = site_t'(c);
			if (link_one[a] == NO_BOND) link_one[a] = bond_t'(b);
			else link_two[a] = bond_t'(b);
			if (link_one[b] == c) link_one[b] = bond_t'(a);
			else link_two[b] = bond_t'(a);
			if (link_one[c] == b) link_one[c] = NO_BOND;
			else link_two[c] = NO_BOND;
			return r;
		endfunction

		function void note_request(req_t kind, site_t s, bond_t b1, bond_t b2,
				slot_t sl, dir_t dr, logic cn);
			reconnect_result_t want;
			want = predict(kind, s, b1, b2, sl, dr, cn);
			kind_tally[kind]++;
			if (kind == REQ_MOVE) move_tally[want.status]++;
			owed.push_back(want);
		endfunction

		function int differ(string field, logic [BOND_W-1:0] want, logic [BOND_W-1:0] got);
			if (got === want) return 0;
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			return 1;
		endfunction

		function void check_result(reconnect_result_t got);
			reconnect_result_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status expected none actual %0d",
					$time, got.status);
				return;
			end
			want = owed.pop_front();
			errors += differ("status", want.status, got.status);
			errors += differ("read_one", want.read_one, got.read_one);
			errors += differ("read_two", want.read_two, got.read_two);
			errors += differ("moved_a", want.moved_a, got.moved_a);
			errors += differ("moved_b", want.moved_b, got.moved_b);
			errors += differ("moved_c", want.moved_c, got.moved_c);
		endfunction
	endclass

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     cfg_we    = 1'b0;
	cfg_idx_t cfg_index = CFG_DIM;
	cfg_dat_t cfg_data  = '0;
	logic     start     = 1'b0;
	logic     busy;
	req_t     req_type  = REQ_READ_BONDS;
	site_t    site      = '0;
	bond_t    bond_one  = '0;
	bond_t    bond_two  = '0;
	slot_t    slot      = '0;
	dir_t     direction = '0;
	logic     coin      = 1'b0;
	logic     done;
	status_t  status;
	bond_t    read_one;
	bond_t    read_two;
	site_t    moved_a;
	site_t    moved_b;
	bond_t    moved_c;

	move_scoreboard sb = new();
	bit             steady = 1'b0;
	int             settings = 1;
	int             cycles = 0;

	lattice_chain_reconnect_move dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin : watch
		reconnect_result_t got;
		if (arst_n && done) begin
			got.status   = status;
			got.read_one = read_one;
			got.read_two = read_two;
			got.moved_a  = moved_a;
			got.moved_b  = moved_b;
			got.moved_c  = moved_c;
			sb.check_result(got);
		end
	end

	// one request transaction; start stays high until the next one or an idle
	task automatic issue(req_t kind, site_t s, bond_t b1, bond_t b2, slot_t sl, dir_t dr,
			logic cn);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0) steady = !steady;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req_type  <= kind;
		site      <= s;
		bond_one  <= b1;
		bond_two  <= b2;
		slot      <= sl;
		direction <= dr;
		coin      <= cn;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(kind, s, b1, b2, sl, dr, cn);
	endtask

	// unused fields carry junk
	task automatic put_bonds(int unsigned s, int unsigned b1, int unsigned b2);
		issue(REQ_WRITE_BONDS, site_t'(s), bond_t'(b1), bond_t'(b2), slot_t'($urandom()),
			dir_t'($urandom()), 1'($urandom()));
	endtask

	task automatic put_slot(int unsigned sl, int unsigned s);
		issue(REQ_WRITE_SLOT, site_t'(s), bond_t'($urandom()), bond_t'($urandom()),
			slot_t'(sl), dir_t'($urandom()), 1'($urandom()));
	endtask

	task automatic put_move(int unsigned sl, int unsigned dr, int unsigned cn);
		issue(REQ_MOVE, site_t'($urandom()), bond_t'($urandom()), bond_t'($urandom()),
			slot_t'(sl), dir_t'(dr), 1'(cn));
	endtask

	task automatic get_bonds(int unsigned s);
		issue(REQ_READ_BONDS, site_t'(s), bond_t'($urandom()), bond_t'($urandom()),
			slot_t'($urandom()), dir_t'($urandom()), 1'($urandom()));
	endtask

	// stop sending and let every owed result come back
	task automatic drain();
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly inside the lattice, sometimes anywhere in the table
	function automatic int unsigned pick_site(int unsigned n);
		if (n <= MAX_SITES && $urandom_range(0, 3) != 0) return $urandom_range(0, n - 1);
		return $urandom_range(0, MAX_SITES - 1);
	endfunction

	function automatic int unsigned pick_link(int unsigned n);
		case ($urandom_range(0, 2))
			0:       return NO_BOND;
			1:       return pick_site(n);
			default: return $urandom_range(0, 8191);
		endcase
	endfunction

	// registers change only while idle; upper bits of the dim and side data carry junk
	task automatic set_config(int unsigned d, int unsigned s, int unsigned c);
		cfg_dat_t dw, sw, cw, xw;
		dw = cfg_dat_t'($urandom());
		dw[DIM_W-1:0] = DIM_W'(d);
		sw = cfg_dat_t'($urandom());
		sw[SIDE_W-1:0] = SIDE_W'(s);
		cw = cfg_dat_t'(c);
		xw = cfg_dat_t'($urandom());
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DIM;
		cfg_data  <= dw;
		@(posedge clk);
		cfg_index <= CFG_SIDE;
		cfg_data  <= sw;
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_data  <= cw;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= xw;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(CFG_DIM, dw);
		sb.configure(CFG_SIDE, sw);
		sb.configure(CFG_COUNT, cw);
		sb.configure(CFG_SPARE, xw);
		@(posedge clk);
		settings++;
	endtask

	// load the lattice with chains (plus a few loose sites) and fill every slot in use
	task automatic lay_chains(bit shuffle);
		int unsigned n, cnt, k, m, lo, hi, j, tmp;
		int unsigned order [$];
		site_t       heads [$];
		site_t       tails [$];
		bond_t       back, fwd;
		n = sb.lattice_sites();
		if (n > MAX_SITES) return;
		cnt = sb.slot_limit();
		for (int i = 0; i < n; i++) order.push_back(i);
		if (shuffle) begin
			for (int i = n - 1; i > 0; i--) begin
				j        = $urandom_range(0, i);
				tmp      = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		k = cnt / 2;
		if (k > n / 4) k = n / 4;
		if (k == 0) k = 1;
		m = n - $urandom_range(0, n / 8);
		for (int ch = 0; ch < k; ch++) begin
			lo = ch * m / k;
			hi = (ch + 1) * m / k;
			heads.push_back(site_t'(order[lo]));
			tails.push_back(site_t'(order[hi - 1]));
			for (int p = lo; p < hi; p++) begin
				back = (p > lo) ? bond_t'(order[p - 1]) : NO_BOND;
				fwd  = (p < hi - 1) ? bond_t'(order[p + 1]) : NO_BOND;
				if ($urandom_range(0, 1)) put_bonds(order[p], fwd, back);
				else put_bonds(order[p], back, fwd);
			end
		end
		for (int p = m; p < n; p++) put_bonds(order[p], NO_BOND, NO_BOND);
		for (int s = 0; s < cnt; s++) begin
			if (s < 2 * k) put_slot(s, s[0] ? tails[s / 2] : heads[s / 2]);
			else put_slot(s, pick_site(n));
		end
	endtask

	// mostly legal moves on live slots, the rest is noise
	task automatic random_items(int unsigned total);
		int unsigned n, cnt, dims, pick, sl;
		for (int i = 0; i < total; i++) begin
			n    = sb.lattice_sites();
			cnt  = sb.slot_limit();
			dims = sb.axes();
			if ($urandom_range(0, 63) == 0) drain();
			pick = $urandom_range(0, 99);
			if (pick < 62 && cnt > 0) begin
				sl = $urandom_range(0, cnt - 1);
				if (sb.may_move(sl))
					put_move(sl, $urandom_range(0, 2 * dims - 1), $urandom_range(0, 1));
				else
					put_slot(sl, pick_site(n));
			end else if (pick < 72) begin
				sl = $urandom_range(0, MAX_ENDPOINTS - 1);
				if (sb.may_move(sl)) put_move(sl, $urandom_range(0, 7), $urandom_range(0, 1));
				else put_slot(sl, pick_site(n));
			end else if (pick < 82) begin
				get_bonds(pick_site(n));
			end else if (pick < 93) begin
				put_bonds(pick_site(n), pick_link(n), pick_link(n));
			end else begin
				sl = (cnt > 0 && $urandom_range(0, 1)) ? $urandom_range(0, cnt - 1)
					: $urandom_range(0, MAX_ENDPOINTS - 1);
				put_slot(sl, pick_site(n));
			end
		end
	endtask

	task automatic run_phase(int unsigned d, int unsigned s, int unsigned c,
			int unsigned total);
		set_config(d, s, c);
		lay_chains($urandom_range(0, 1));
		random_items(total);
	endtask

	// run watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still owed", cycles, sb.outstanding());
		$display("lattice_chain_reconnect_move_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: the 3-D lattice fills the whole bond table
		lay_chains(1'b1);

		// hand-built neighborhood around site 5, axis 0 stride 1, axis 1 stride 16
		put_bonds(5, 6, 8191);
		put_bonds(4, 20, 36);
		put_bonds(20, 4, 21);
		put_bonds(36, 4, NO_BOND);
		put_slot(0, 5);
		put_move(0, 0, 1);          // C=36 is itself an end
		put_move(0, 0, 0);          // C=20, accepted
		get_bonds(4);
		get_bonds(20);
		put_move(0, 1, 0);          // A=20 already holds 21
		put_bonds(19, NO_BOND, 4097);
		put_move(0, 0, 0);          // B=19 has no links
		put_bonds(19, NO_BOND, 18);
		put_bonds(18, 17, 19);
		put_move(0, 0, 1);          // single link on B, coin has no say
		put_bonds(21, 22, 37);
		put_bonds(6, 7, 5);
		put_slot(1, 21);
		put_move(1, 2, 0);          // A has both links, second one replaced
		put_slot(1, 0);
		put_move(1, 4, 1);          // wraps at coordinate zero
		put_slot(1, 4095);
		put_move(1, 5, 0);          // wraps at the top coordinate
		put_move(1, 6, 0);          // direction past the lattice axes
		put_move(1, 7, 1);
		put_move(2, 0, 0);          // slot past the count
		put_slot(255, 4095);
		put_move(255, 3, 1);
		put_bonds(4095, 0, 4095);
		get_bonds(4095);
		get_bonds(0);
		random_items(120);

		// register sweep: clamps, tiny and wide lattices, oversize lattice, odd counts
		run_phase(2, 2, 2, 60);
		run_phase(2, 16, 256, 150);
		run_phase(0, 1, 0, 40);
		run_phase(7, 31, 511, 50);
		run_phase(4, 3, 20, 150);
		run_phase(3, 5, 1, 80);
		run_phase(4, 2, 6, 100);
		run_phase(3, 3, 10, 100);
		run_phase(1, 17, 12, 100);
		run_phase(2, 7, 30, 100);

		drain();
		$display("%0d register settings; %0d bond writes, %0d slot writes, %0d reads, %0d moves",
			settings, sb.kind_tally[REQ_WRITE_BONDS], sb.kind_tally[REQ_WRITE_SLOT],
			sb.kind_tally[REQ_READ_BONDS], sb.kind_tally[REQ_MOVE]);
		$display("moves: %0d rewired, %0d bonded, %0d C end, %0d isolated, %0d invalid",
			sb.move_tally[ST_OK], sb.move_tally[ST_BONDED], sb.move_tally[ST_C_END],
			sb.move_tally[ST_ISOLATED], sb.move_tally[ST_BAD]);
		if (sb.errors == 0) begin
			$display("lattice_chain_reconnect_move_tb: PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("lattice_chain_reconnect_move_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lcrm_pkg.sv
rtl/core/lcrm_ram.sv
rtl/core/lattice_chain_reconnect_move.sv
rtl/core/lcrm_checker.sv
dv/lattice_chain_reconnect_move_tb.sv
